/* rtl/core/wrol_pkg.sv */
// shared types and constants for the write ring offset lookup core
`timescale 1ns / 1ps
`default_nettype none

package wrol_pkg;

   // default sizing
   localparam int DEF_SLOTS       = 16;
   localparam int DEF_LENGTH_BITS = 20;

   // fixed field widths
   localparam int IN_LEN_W   = 20;
   localparam int HANDLE_W   = 32;
   localparam int OFFSET_W   = 24;
   localparam int SLOT_IDX_W = 4;
   localparam int OUT_LEN_W  = 20;

   // bus widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 112;

   // operation codes
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic                  found;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [HANDLE_W-1:0]   record_handle;
      logic [OUT_LEN_W-1:0]  byte_in_record;
      logic                  evicted;
      logic [OUT_LEN_W-1:0]  evicted_length;
      logic [HANDLE_W-1:0]   evicted_handle;
   } result_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/wrol_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wrol_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/wrol_ctrl.sv */
// ring pointers, add sequencing and oldest-first lookup walk over the record ram
`timescale 1ns / 1ps
`default_nettype none

module wrol_ctrl #(
   parameter int SLOTS       = wrol_pkg::DEF_SLOTS,
   parameter int LENGTH_BITS = wrol_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   input  wire logic                                       req_func,
   input  wire logic [wrol_pkg::IN_LEN_W-1:0]              req_length,
   input  wire logic [wrol_pkg::HANDLE_W-1:0]              req_handle,
   input  wire logic [wrol_pkg::OFFSET_W-1:0]              req_offset,
   output      logic                                       req_ready,
   input  wire logic                                       out_free,
   output      logic                                       emit,
   output      wrol_pkg::result_type                       result,
   output      wrol_pkg::ram_ctl_type                      ram_ctl,
   output      logic [$clog2(SLOTS)-1:0]                   ram_addr,
   output      logic [LENGTH_BITS+wrol_pkg::HANDLE_W-1:0]  ram_wdata,
   input  wire logic [LENGTH_BITS+wrol_pkg::HANDLE_W-1:0]  ram_rdata
);

   import wrol_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (LENGTH_BITS > OFFSET_W) ? LENGTH_BITS : OFFSET_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_LOOK,
      ST_EMIT
   } state_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0]      rd_slot_ff, rd_slot_in;
   logic                   full_ff, full_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [OFFSET_W-1:0]    offs_ff, offs_in;
   logic [IN_LEN_W-1:0]    len_ff, len_in;
   logic [HANDLE_W-1:0]    handle_ff, handle_in;
   result_type             res_ff, res_in;

   logic [LENGTH_BITS-1:0] rd_len;
   logic [HANDLE_W-1:0]    rd_handle;
   logic [CNT_W-1:0]       count;
   logic [SLOT_W-1:0]      idx_next;
   logic                   hit;
   logic [CMP_W-1:0]       diff;

   assign rd_len    = ram_rdata[LENGTH_BITS-1:0];
   assign rd_handle = ram_rdata[LENGTH_BITS +: HANDLE_W];
   assign idx_next  = next_slot(idx_ff);
   assign hit       = CMP_W'(offs_ff) < CMP_W'(rd_len);
   assign diff      = CMP_W'(offs_ff) - CMP_W'(rd_len);

   // stored records between read and write slot
   always_comb begin
      if (full_ff) begin
         count = CNT_W'(SLOTS);
      end else if (wr_slot_ff >= rd_slot_ff) begin
         count = CNT_W'(wr_slot_ff) - CNT_W'(rd_slot_ff);
      end else begin
         count = CNT_W'(SLOTS) - CNT_W'(rd_slot_ff) + CNT_W'(wr_slot_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      full_in    = full_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      offs_in    = offs_ff;
      len_in     = len_ff;
      handle_in  = handle_ff;
      res_in     = res_ff;
      ram_ctl    = '0;
      ram_addr   = idx_next;
      ram_wdata  = {handle_ff, LENGTH_BITS'(len_ff)};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_ADD) begin
                  // fetch the record about to be overwritten
                  ram_ctl.rd_en = 1'b1;
                  ram_addr      = wr_slot_ff;
                  len_in        = req_length;
                  handle_in     = req_handle;
                  state_in      = ST_ADD;
               end else begin
                  ram_ctl.rd_en = 1'b1;
                  ram_addr      = rd_slot_ff;
                  idx_in        = rd_slot_ff;
                  rem_in        = count;
                  offs_in       = req_offset;
                  if (count == '0) begin
                     res_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_LOOK;
                  end
               end
            end
         end
         ST_ADD: begin
            ram_ctl.wr_en         = 1'b1;
            ram_addr              = wr_slot_ff;
            res_in.found          = 1'b1;
            res_in.slot_index     = SLOT_IDX_W'(wr_slot_ff);
            res_in.record_handle  = handle_ff;
            res_in.byte_in_record = '0;
            res_in.evicted        = full_ff;
            res_in.evicted_length = full_ff ? OUT_LEN_W'(rd_len) : '0;
            res_in.evicted_handle = full_ff ? rd_handle : '0;
            wr_slot_in            = next_slot(wr_slot_ff);
            rd_slot_in            = full_ff ? next_slot(rd_slot_ff) : rd_slot_ff;
            full_in               = (wr_slot_in == rd_slot_in);
            state_in              = ST_EMIT;
         end
         ST_LOOK: begin
            if (hit) begin
               res_in.found          = 1'b1;
               res_in.slot_index     = SLOT_IDX_W'(idx_ff);
               res_in.record_handle  = rd_handle;
               res_in.byte_in_record = OUT_LEN_W'(offs_ff);
               res_in.evicted        = 1'b0;
               res_in.evicted_length = '0;
               res_in.evicted_handle = '0;
               state_in              = ST_EMIT;
            end else begin
               offs_in = diff[OFFSET_W-1:0];
               if (rem_ff == CNT_W'(1)) begin
                  // walked past the newest record
                  res_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  rem_in        = rem_ff - 1'b1;
                  idx_in        = idx_next;
                  ram_ctl.rd_en = 1'b1;
                  ram_addr      = idx_next;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wr_slot_ff <= '0;
         rd_slot_ff <= '0;
         full_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         full_ff    <= full_in;
      end
      idx_ff    <= idx_in;
      rem_ff    <= rem_in;
      offs_ff   <= offs_in;
      len_ff    <= len_in;
      handle_ff <= handle_in;
      res_ff    <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign emit      = (state_ff == ST_EMIT) && out_free;
   assign result    = res_ff;

endmodule

`default_nettype wire

/* rtl/core/write_ring_offset_lookup_core.sv */
// top level of the write ring offset lookup core: record ram, controller, output register
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: func; tdata: length, handle, offset
// rsp      out  rsp_tvalid/rsp_tready  tuser: found; tdata: slot, handles, lengths
//
// an add steps through accepting and reading the slot, writing back, and handing over the word
// a lookup walks 0 to SLOTS records oldest first, one ram read a cycle
// the single-port record ram sets the pace; one word is in work at a time
// reset clears the pointers, full flag, state and output valid only; the ram needs no clearing pass
// a finished word waits in the output register while the next word is taken in

module write_ring_offset_lookup_core #(
   parameter int SLOTS       = wrol_pkg::DEF_SLOTS,
   parameter int LENGTH_BITS = wrol_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic                            req_tuser,  // func
   // write_length [19:0], write_handle [51:20], char_pos [75:52], zero pad
   input  wire logic [wrol_pkg::REQ_DATA_W-1:0] req_tdata,
   // response channel
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic                            rsp_tuser,  // found
   // slot_index [3:0], record_handle [35:4], byte_in_record [55:36], evicted [56],
   // evicted_length [76:57], evicted_handle [108:77], zero pad
   output      logic [wrol_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import wrol_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int REC_W  = LENGTH_BITS + HANDLE_W;
   localparam int PAD_W  = RSP_DATA_W - SLOT_IDX_W - 2 * HANDLE_W - 2 * OUT_LEN_W - 1;

   // request unpacking
   logic [IN_LEN_W-1:0] req_length;
   logic [HANDLE_W-1:0] req_handle;
   logic [OFFSET_W-1:0] req_offset;

   assign req_length = req_tdata[IN_LEN_W-1:0];
   assign req_handle = req_tdata[IN_LEN_W +: HANDLE_W];
   assign req_offset = req_tdata[IN_LEN_W + HANDLE_W +: OFFSET_W];

   // controller to ram
   ram_ctl_type       ram_ctl;
   logic [SLOT_W-1:0] ram_addr;
   logic [REC_W-1:0]  ram_wdata;
   logic [REC_W-1:0]  ram_rdata;

   // controller to output register
   logic       out_free;
   logic       emit;
   result_type result;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff;

   // one record per slot: length in the low bits, handle above
   wrol_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_record_ram (
      .clock   (clock),
      .rd_en   (ram_ctl.rd_en),
      .wr_en   (ram_ctl.wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // reads and writes never overlap: one word at a time, so no forwarding
   wrol_ctrl #(
      .SLOTS       (SLOTS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_func   (req_tuser),
      .req_length (req_length),
      .req_handle (req_handle),
      .req_offset (req_offset),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .emit       (emit),
      .result     (result),
      .ram_ctl    (ram_ctl),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata)
   );

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_word_ff <= result;
      end
   end

   // response packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_word_ff.found;
   assign rsp_tdata  = {PAD_W'(0),
                        rsp_word_ff.evicted_handle,
                        rsp_word_ff.evicted_length,
                        rsp_word_ff.evicted,
                        rsp_word_ff.byte_in_record,
                        rsp_word_ff.record_handle,
                        rsp_word_ff.slot_index};

   // a taken word leaves the block busy in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous word still in work");

   // a new result never overwrites a word that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending response word");

   // eviction only comes with a completed add
   a_evict_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.evicted) |-> rsp_word_ff.found)
      else $error("eviction reported without a completed add");

   // a miss reports an all-zero word
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.found) |->
         (rsp_word_ff.slot_index == '0 && rsp_word_ff.record_handle == '0 &&
          rsp_word_ff.byte_in_record == '0 && rsp_word_ff.evicted_length == '0))
      else $error("lookup miss carries stale fields");

endmodule

`default_nettype wire

/* dv/tb_write_ring_offset_lookup_core.sv */
// self-checking testbench for the write ring offset lookup core
`timescale 1ns / 1ps

module tb_write_ring_offset_lookup_core;

   import wrol_pkg::*;

   localparam int RING_SLOTS    = DEF_SLOTS;
   localparam int PHASE_WORDS   = 150;   // random words per idling phase
   localparam int HOLD_AFTER    = 60;    // responses taken before the long hold-off
   localparam int HOLD_CYCLES   = 400;   // length of the long receiver hold-off
   localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES = 40;    // drain time after the last response

   typedef enum int {
      STEADY,
      SENDER_GAPS,
      RECEIVER_STALLS,
      BOTH_IDLE
   } idle_mode_type;

   typedef struct {
      logic                op;
      logic [IN_LEN_W-1:0] length;
      logic [HANDLE_W-1:0] handle;
      logic [OFFSET_W-1:0] offset;
      idle_mode_type       mode;
      bit                  drain;  // hold back until every response is in
   } ring_request_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // request channel, driven from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;               // func
   logic [REQ_DATA_W-1:0] req_tdata  = '0;                 // length, handle, offset, pad

   // response channel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tuser;                       // found
   logic [RSP_DATA_W-1:0] rsp_tdata;                       // slot, handle, byte, eviction

   write_ring_offset_lookup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // words waiting to be offered, and responses still owed by the block
   ring_request_type request_queue[$];
   result_type       expected_results[$];

   idle_mode_type idle_mode = STEADY;
   int            in_flight;
   int            outstanding;
   int            responses_taken;
   int            hold_left;
   int            quiet_cycles;
   int            mismatches = 0;

   // shadow of the record ring
   logic [IN_LEN_W-1:0]   ring_len    [RING_SLOTS];
   logic [HANDLE_W-1:0]   ring_handle [RING_SLOTS];
   logic [SLOT_IDX_W-1:0] ring_wr     = '0;
   logic [SLOT_IDX_W-1:0] ring_rd     = '0;
   logic                  ring_is_full = 1'b0;

   // work out the response to one word and move the shadow ring along
   function automatic result_type ring_outcome(input logic                op,
                                               input logic [IN_LEN_W-1:0] length,
                                               input logic [HANDLE_W-1:0] handle,
                                               input logic [OFFSET_W-1:0] offset);
      result_type            r;
      logic [OFFSET_W-1:0]   remaining;
      logic [SLOT_IDX_W-1:0] slot;
      int                    stored;
      r = '0;
      if (op == FUNC_ADD) begin
         // a full ring gives up its oldest record, which sits at the write slot
         if (ring_is_full) begin
            r.evicted        = 1'b1;
            r.evicted_length = ring_len[ring_wr];
            r.evicted_handle = ring_handle[ring_wr];
            ring_rd          = ring_rd + 1'b1;
         end
         ring_len[ring_wr]    = length;
         ring_handle[ring_wr] = handle;
         r.found              = 1'b1;
         r.slot_index         = ring_wr;
         r.record_handle      = handle;
         ring_wr              = ring_wr + 1'b1;
         ring_is_full         = (ring_wr == ring_rd);
      end else begin
         // walk oldest first; zero-length records are passed over naturally
         slot      = ring_wr - ring_rd;
         stored    = ring_is_full ? RING_SLOTS : int'(slot);
         remaining = offset;
         for (int i = 0; i < stored; i++) begin
            slot = ring_rd + SLOT_IDX_W'(i);
            if (remaining < OFFSET_W'(ring_len[slot])) begin
               r.found          = 1'b1;
               r.slot_index     = slot;
               r.record_handle  = ring_handle[slot];
               r.byte_in_record = remaining[OUT_LEN_W-1:0];
               return r;
            end
            remaining = remaining - OFFSET_W'(ring_len[slot]);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic queue_word(input logic op, input logic [IN_LEN_W-1:0] length,
                             input logic [HANDLE_W-1:0] handle,
                             input logic [OFFSET_W-1:0] offset,
                             input idle_mode_type mode, input bit drain);
      ring_request_type w;
      w.op     = op;
      w.length = length;
      w.handle = handle;
      w.offset = offset;
      w.mode   = mode;
      w.drain  = drain;
      request_queue.push_back(w);
   endtask

   // driver: offers the next word once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         in_flight  <= 0;
      end else begin
         outstanding = in_flight + int'(req_tvalid && req_tready)
                       - int'(rsp_tvalid && rsp_tready);
         in_flight <= outstanding;
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() != 0
                && !(request_queue[0].drain && outstanding != 0)
                && !(request_queue[0].mode == SENDER_GAPS
                     && $urandom_range(99) < 60)
                && !(request_queue[0].mode == BOTH_IDLE
                     && $urandom_range(99) < 22)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= request_queue[0].op;
               req_tdata  <= {4'b0, request_queue[0].offset, request_queue[0].handle,
                              request_queue[0].length};
               idle_mode  <= request_queue[0].mode;
               void'(request_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls by phase, plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready      <= 1'b0;
         responses_taken <= 0;
         hold_left       <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            responses_taken <= responses_taken + 1;
         if (rsp_tvalid && rsp_tready && responses_taken == HOLD_AFTER - 1) begin
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_mode == RECEIVER_STALLS) begin
            rsp_tready <= ($urandom_range(99) >= 60);
         end else if (idle_mode == BOTH_IDLE) begin
            rsp_tready <= ($urandom_range(99) >= 22);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: predicts on each accepted request word, checks each response word
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing owed", {31'b0, rsp_tuser}, 32'b0);
            end else begin
               want = expected_results.pop_front();
               check_field("found", 32'(rsp_tuser), 32'(want.found));
               check_field("slot_index", 32'(rsp_tdata[3:0]), 32'(want.slot_index));
               check_field("record_handle", rsp_tdata[35:4], want.record_handle);
               check_field("byte_in_record", 32'(rsp_tdata[55:36]),
                           32'(want.byte_in_record));
               check_field("evicted", 32'(rsp_tdata[56]), 32'(want.evicted));
               check_field("evicted_length", 32'(rsp_tdata[76:57]),
                           32'(want.evicted_length));
               check_field("evicted_handle", rsp_tdata[108:77], want.evicted_handle);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(ring_outcome(req_tuser, req_tdata[19:0],
                                                    req_tdata[51:20], req_tdata[75:52]));
      end
   end

   // watchdog: any handshake resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("write_ring_offset_lookup_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [IN_LEN_W-1:0] length;
      logic [OFFSET_W-1:0] offset;
      idle_mode_type       mode;

      // directed: empty ring, zero-length and maximum records, offset edges
      queue_word(FUNC_LOOKUP, '0, '0, '0, STEADY, 1'b1);
      queue_word(FUNC_LOOKUP, '0, '0, 24'hFFFFFF, STEADY, 1'b0);
      queue_word(FUNC_ADD, '0, '0, '0, STEADY, 1'b0);
      queue_word(FUNC_ADD, 20'hFFFFF, 32'hFFFFFFFF, '0, STEADY, 1'b0);
      queue_word(FUNC_ADD, 20'd1, $urandom, 24'hFFFFFF, STEADY, 1'b0);
      queue_word(FUNC_LOOKUP, 20'hFFFFF, 32'hFFFFFFFF, 24'h000000, STEADY, 1'b0);
      queue_word(FUNC_LOOKUP, '0, '0, 24'h0FFFFE, STEADY, 1'b0);
      queue_word(FUNC_LOOKUP, '0, '0, 24'h0FFFFF, STEADY, 1'b0);
      queue_word(FUNC_LOOKUP, '0, '0, 24'h100000, STEADY, 1'b0);
      // fill the ring to all sixteen slots
      for (int i = 0; i < RING_SLOTS - 3; i++)
         queue_word(FUNC_ADD, 20'($urandom_range(1, 300)), $urandom, '0, STEADY, 1'b0);
      // wrap: evicts the zero-length record, then the maximum one
      queue_word(FUNC_ADD, 20'd7, $urandom, '0, STEADY, 1'b0);
      queue_word(FUNC_ADD, 20'd9, $urandom, '0, STEADY, 1'b0);
      queue_word(FUNC_LOOKUP, '0, '0, 24'd5, STEADY, 1'b0);
      queue_word(FUNC_LOOKUP, '0, '0, 24'hFFFFFF, STEADY, 1'b0);

      // random words, one idling phase after another
      for (int n = 0; n < 4 * PHASE_WORDS; n++) begin
         mode = idle_mode_type'(n / PHASE_WORDS);
         case ($urandom_range(9))
            0:       length = '0;
            1, 2, 3,
            4:       length = 20'($urandom_range(1, 40));
            5, 6:    length = 20'($urandom);
            7:       length = 20'hFFFFF;
            default: length = 20'($urandom_range(41, 4095));
         endcase
         case ($urandom_range(9))
            0, 1, 2,
            3:       offset = 24'($urandom_range(0, 150));
            4, 5:    offset = 24'($urandom_range(0, 40000));
            9:       offset = 24'hFFFFFF;
            default: offset = 24'($urandom);
         endcase
         queue_word(($urandom_range(99) < 45) ? FUNC_ADD : FUNC_LOOKUP, length, $urandom,
                    offset, mode, (n % PHASE_WORDS) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to go in and every response to come back
      @(posedge clock);
      while (request_queue.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("write_ring_offset_lookup_core: match");
      end else begin
         $display("write_ring_offset_lookup_core: mismatch");
      end
      $finish;
   end

endmodule
